// ===== rtl/pts_pkg.sv =====
`timescale 1ns / 1ps

package pts_pkg;

   localparam int NUM_PRIORITIES = 32;
   localparam int COUNTER_BITS   = 32;
   localparam int SLOT_BITS      = $clog2(NUM_PRIORITIES);

   localparam logic [5:0] TASK_MAX = 6'd63;

   typedef enum logic [1:0] {
      KIND_CREATE = 2'd0,
      KIND_DELAY  = 2'd1,
      KIND_TICK   = 2'd2,
      KIND_SELECT = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OCCUPIED = 2'd1,
      STATUS_NONE     = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_SELECT = 1'b1
   } state_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic                    create;
      logic                    delay;
      logic                    tick;
      logic [COUNTER_BITS-1:0] delay_value;
   } cell_cmd_type;

   typedef struct packed {
      logic present;
      logic ready;
   } cell_state_type;

endpackage

// ===== rtl/pts_if.sv =====
`timescale 1ns / 1ps

interface pts_req_if;
   logic              valid;
   logic              ready;
   pts_pkg::kind_type kind;
   logic [7:0]        task_priority;
   logic [31:0]       delay_ticks;

   modport source (output valid, output kind, output task_priority, output delay_ticks,
                   input ready);
   modport sink   (input valid, input kind, input task_priority, input delay_ticks,
                   output ready);
endinterface

interface pts_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  current_priority;
   logic        has_current;
   logic [31:0] ready_mask;
   logic [31:0] tick_count;
   logic [5:0]  task_count;
   logic [1:0]  status;

   modport source (output valid, output current_priority, output has_current,
                   output ready_mask, output tick_count, output task_count, output status,
                   input ready);
   modport sink   (input valid, input current_priority, input has_current,
                   input ready_mask, input tick_count, input task_count, input status,
                   output ready);
endinterface

// ===== rtl/priority_task_scheduler_with_delays.sv =====
`timescale 1ns / 1ps

// Task scheduler with one slot per priority level, the higher number winning. Each request
// (create, delay the running task, tick, select) returns one response carrying the running
// slot, the ready bitmap, the tick count, the task count and a status. A request passes through
// the idle and select states: when it is accepted the row of slot cells applies the update (the
// nonzero delay counters of present slots count down in parallel on a tick), and in the select
// state the priority encoder over the ready bits picks the running slot and the response register
// loads. The select state holds for as long as a previous response is still held on the output,
// so no new request is taken until the response of the last one has loaded.
module priority_task_scheduler_with_delays (
   input  logic     clock,
   input  logic     reset,
   pts_req_if.sink  req_bus,
   pts_rsp_if.source rsp_bus
);

   localparam int N  = pts_pkg::NUM_PRIORITIES;
   localparam int SB = pts_pkg::SLOT_BITS;

   pts_pkg::state_type    state_ff, state_in;
   pts_pkg::kind_type     kind_ff, kind_in;
   logic                  occupied_ff, occupied_in;
   logic                  norun_ff, norun_in;
   logic [SB-1:0]         running_slot_ff, running_slot_in;
   logic                  running_valid_ff, running_valid_in;
   logic [31:0]           ticks_ff, ticks_in;
   logic [5:0]            tasks_ff, tasks_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [4:0]            rsp_prio_ff, rsp_prio_in;
   logic                  rsp_has_ff, rsp_has_in;
   logic [31:0]           rsp_mask_ff, rsp_mask_in;
   logic [31:0]           rsp_ticks_ff, rsp_ticks_in;
   logic [5:0]            rsp_tasks_ff, rsp_tasks_in;
   pts_pkg::status_type   rsp_status_ff, rsp_status_in;

   logic                  accept, commit, out_free;
   logic [SB-1:0]         slot_clamped, target;
   logic                  occupied, create_ok, delay_ok;
   logic [63:0]           delay_wide;
   logic [N-1:0]          sel, present_vec, ready_vec;
   pts_pkg::cell_cmd_type cmd;
   pts_pkg::cell_state_type cell_state [N];
   logic                  any_ready, do_reselect;
   logic [SB-1:0]         top_slot;
   logic [SB-1:0]         next_slot;
   logic                  next_valid;
   pts_pkg::status_type   next_status;
   logic [7:0]            slot_wide;
   logic [63:0]           ready_wide;

   // state machine
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pts_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = pts_pkg::ST_SELECT;
            end
         end
         pts_pkg::ST_SELECT: begin
            if (out_free) begin
               state_in = pts_pkg::ST_IDLE;
            end
         end
         default: state_in = pts_pkg::ST_IDLE;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      req_bus.ready = 1'b0;
      commit        = 1'b0;
      unique case (state_ff)
         pts_pkg::ST_IDLE:   req_bus.ready = !reset;
         pts_pkg::ST_SELECT: commit        = out_free;
         default: begin
            req_bus.ready = 1'b0;
            commit        = 1'b0;
         end
      endcase
   end

   assign accept = req_bus.valid && req_bus.ready;

   // request decode
   assign slot_clamped = (req_bus.task_priority >= 8'(N)) ? SB'(N - 1)
                                                          : req_bus.task_priority[SB-1:0];
   assign occupied  = present_vec[slot_clamped];
   assign create_ok = (req_bus.kind == pts_pkg::KIND_CREATE) && !occupied;
   assign delay_ok  = (req_bus.kind == pts_pkg::KIND_DELAY) && running_valid_ff;
   assign target    = (req_bus.kind == pts_pkg::KIND_CREATE) ? slot_clamped : running_slot_ff;
   assign delay_wide = 64'(req_bus.delay_ticks);

   assign cmd.create      = accept && create_ok;
   assign cmd.delay       = accept && delay_ok;
   assign cmd.tick        = accept && (req_bus.kind == pts_pkg::KIND_TICK);
   assign cmd.delay_value = delay_wide[pts_pkg::COUNTER_BITS-1:0];

   // row of slot cells
   for (genvar i = 0; i < N; i++) begin : g_cell
      assign sel[i] = (target == SB'(i));
      pts_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .sel   (sel[i]),
         .state (cell_state[i])
      );
      assign present_vec[i] = cell_state[i].present;
      assign ready_vec[i]   = cell_state[i].ready;
   end

   pts_select u_select (
      .ready_vec (ready_vec),
      .any_ready (any_ready),
      .top_slot  (top_slot)
   );

   // reselect and status
   always_comb begin
      do_reselect = 1'b0;
      unique case (kind_ff) inside
         pts_pkg::KIND_CREATE:                     do_reselect = 1'b0;
         pts_pkg::KIND_DELAY:                      do_reselect = !norun_ff;
         pts_pkg::KIND_TICK, pts_pkg::KIND_SELECT: do_reselect = 1'b1;
         default:                                  do_reselect = 1'b0;
      endcase
   end

   always_comb begin
      next_slot   = running_slot_ff;
      next_valid  = running_valid_ff;
      next_status = pts_pkg::STATUS_OK;
      if (kind_ff == pts_pkg::KIND_CREATE) begin
         if (occupied_ff) begin
            next_status = pts_pkg::STATUS_OCCUPIED;
         end
      end else if (kind_ff == pts_pkg::KIND_DELAY && norun_ff) begin
         next_status = pts_pkg::STATUS_NONE;
      end
      if (do_reselect) begin
         if (any_ready) begin
            next_slot  = top_slot;
            next_valid = 1'b1;
         end else begin
            next_status = pts_pkg::STATUS_NONE;
         end
      end
   end

   // scheduler state
   always_comb begin
      kind_in          = kind_ff;
      occupied_in      = occupied_ff;
      norun_in         = norun_ff;
      running_slot_in  = running_slot_ff;
      running_valid_in = running_valid_ff;
      ticks_in         = ticks_ff;
      tasks_in         = tasks_ff;
      if (accept) begin
         kind_in     = req_bus.kind;
         occupied_in = occupied;
         norun_in    = !running_valid_ff;
         if (cmd.tick) begin
            ticks_in = ticks_ff + 32'd1;
         end
         if (cmd.create) begin
            if (tasks_ff != pts_pkg::TASK_MAX) begin
               tasks_in = tasks_ff + 6'd1;
            end
            if (!running_valid_ff || (running_slot_ff <= slot_clamped)) begin
               running_slot_in  = slot_clamped;
               running_valid_in = 1'b1;
            end
         end
      end else if (commit) begin
         running_slot_in  = next_slot;
         running_valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= pts_pkg::ST_IDLE;
         running_slot_ff  <= '0;
         running_valid_ff <= 1'b0;
         ticks_ff         <= '0;
         tasks_ff         <= '0;
      end else begin
         state_ff         <= state_in;
         running_slot_ff  <= running_slot_in;
         running_valid_ff <= running_valid_in;
         ticks_ff         <= ticks_in;
         tasks_ff         <= tasks_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      occupied_ff <= occupied_in;
      norun_ff    <= norun_in;
   end

   // response register
   assign slot_wide  = 8'(next_slot);
   assign ready_wide = 64'(ready_vec);

   always_comb begin
      rsp_valid_in  = rsp_bus.ready ? 1'b0 : rsp_valid_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_ticks_in  = rsp_ticks_ff;
      rsp_tasks_in  = rsp_tasks_ff;
      rsp_status_in = rsp_status_ff;
      if (commit) begin
         rsp_valid_in  = 1'b1;
         rsp_prio_in   = slot_wide[4:0];
         rsp_has_in    = next_valid;
         rsp_mask_in   = ready_wide[31:0];
         rsp_ticks_in  = ticks_ff;
         rsp_tasks_in  = tasks_ff;
         rsp_status_in = next_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_prio_ff   <= rsp_prio_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_ticks_ff  <= rsp_ticks_in;
      rsp_tasks_ff  <= rsp_tasks_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.current_priority = rsp_prio_ff;
   assign rsp_bus.has_current      = rsp_has_ff;
   assign rsp_bus.ready_mask       = rsp_mask_ff;
   assign rsp_bus.tick_count       = rsp_ticks_ff;
   assign rsp_bus.task_count       = rsp_tasks_ff;
   assign rsp_bus.status           = rsp_status_ff;

endmodule

// ===== rtl/pts_cell.sv =====
`timescale 1ns / 1ps

module pts_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  pts_pkg::cell_cmd_type     cmd,
   input  logic                      sel,
   output pts_pkg::cell_state_type   state
);

   logic                             present_ff, present_in;
   logic                             ready_ff, ready_in;
   logic [pts_pkg::COUNTER_BITS-1:0] counter_ff, counter_in;

   always_comb begin
      present_in = present_ff;
      ready_in   = ready_ff;
      counter_in = counter_ff;
      if (cmd.create && sel) begin
         present_in = 1'b1;
         ready_in   = 1'b1;
         counter_in = '0;
      end else if (cmd.delay && sel) begin
         counter_in = cmd.delay_value;
         if (cmd.delay_value != '0) begin
            ready_in = 1'b0;
         end
      end else if (cmd.tick && present_ff && (counter_ff != '0)) begin
         counter_in = counter_ff - pts_pkg::COUNTER_BITS'(1);
         if (counter_ff == pts_pkg::COUNTER_BITS'(1)) begin
            ready_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
         ready_ff   <= 1'b0;
         counter_ff <= '0;
      end else begin
         present_ff <= present_in;
         ready_ff   <= ready_in;
         counter_ff <= counter_in;
      end
   end

   assign state.present = present_ff;
   assign state.ready   = ready_ff;

endmodule

// ===== rtl/pts_select.sv =====
`timescale 1ns / 1ps

module pts_select (
   input  logic [pts_pkg::NUM_PRIORITIES-1:0] ready_vec,
   output logic                               any_ready,
   output logic [pts_pkg::SLOT_BITS-1:0]      top_slot
);

   // highest set bit wins
   always_comb begin
      top_slot = '0;
      for (int i = 0; i < pts_pkg::NUM_PRIORITIES; i++) begin
         if (ready_vec[i]) begin
            top_slot = pts_pkg::SLOT_BITS'(i);
         end
      end
   end

   assign any_ready = |ready_vec;

endmodule

// ===== rtl/pts_checker.sv =====
`timescale 1ns / 1ps

module pts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_has_current,
   input logic [31:0] rsp_ready_mask,
   input logic [31:0] rsp_tick_count,
   input logic [5:0]  rsp_task_count,
   input logic [1:0]  rsp_status
);

   // held response keeps its ready mask, tick count and status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ready_mask)
         && $stable(rsp_tick_count) && $stable(rsp_status))
      else $error("response changed while stalled");

   a_task_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_task_count <= 6'(pts_pkg::NUM_PRIORITIES)))
      else $error("task count above slot count");

   // an occupied slot implies some task exists
   a_occupied_has: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == pts_pkg::STATUS_OCCUPIED) |-> rsp_has_current)
      else $error("occupied status without a running task");

   a_empty_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_current |-> (rsp_ready_mask == 32'd0)
         && (rsp_task_count == 6'd0))
      else $error("ready bits set before any task was created");

endmodule

bind priority_task_scheduler_with_delays pts_checker u_pts_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_has_current (rsp_bus.has_current),
   .rsp_ready_mask  (rsp_bus.ready_mask),
   .rsp_tick_count  (rsp_bus.tick_count),
   .rsp_task_count  (rsp_bus.task_count),
   .rsp_status      (rsp_bus.status)
);
